// File: sv/nsu_pkg.sv
// ============================================================================
// nsu_pkg - shared types and constants of the null-split UTF-8 string scanner
// Field widths, byte class constants and the item/result structs that pass
// between the scanner stages.
// ============================================================================
package nsu_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 24;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Byte class constants
    localparam logic [BYTE_W-1:0] BYTE_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_DEL       = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_PATTERN   = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_2BYTE     = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_3BYTE     = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_4BYTE     = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4     = 8'hF8;

    // Continuation counts owed after a lead byte
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        logic [POS_W-1:0] string_offset;
        logic [POS_W-1:0] string_length;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t result;
    } scan_out_t;

endpackage

// File: sv/nsu_if.sv
// ============================================================================
// nsu_if - valid/ready channels of the string scanner
// nsu_byte_if carries one region byte per item; nsu_string_if carries one
// valid string (offset and length) per item.
// ============================================================================
interface nsu_byte_if;
    logic                      valid;
    logic                      ready;
    logic [nsu_pkg::BYTE_W-1:0] byte_value;
    logic                      last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface nsu_string_if;
    logic                      valid;
    logic                      ready;
    logic [nsu_pkg::POS_W-1:0] string_offset;
    logic [nsu_pkg::POS_W-1:0] string_length;

    modport source (output valid, output string_offset, output string_length, input ready);
    modport sink   (input valid, input string_offset, input string_length, output ready);
endinterface

// File: sv/nsu_input_stage.sv
// ============================================================================
// nsu_input_stage - input register of the string scanner
// Captures one byte item per cycle and holds it until the scan stage takes it.
// ============================================================================
module nsu_input_stage (
    input  logic            clk,
    input  logic            rst_n,
    nsu_byte_if.sink        bytes,
    input  logic            advance,
    output nsu_pkg::stage_t stage
);
    import nsu_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // Accept a new item when the register is empty or drains this cycle
    assign bytes.ready = !valid_reg || advance;
    assign take        = bytes.valid && bytes.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the control bit under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on accept
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.byte_value <= bytes.byte_value;
            item_reg.last_byte  <= bytes.last_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: sv/nsu_scan_core.sv
// ============================================================================
// nsu_scan_core - per-byte string state and validity checks
// Tracks position, string start, owed continuation bytes and the bad flag,
// and forms the offset and length of a string as it closes.
// ============================================================================
module nsu_scan_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [nsu_pkg::POS_W-1:0] region_start,
    input  nsu_pkg::stage_t           stage,
    input  logic                      advance,
    output nsu_pkg::scan_out_t        scan
);
    import nsu_pkg::*;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [POS_W-1:0] begin_reg, begin_next;
    logic [1:0]       pend_reg,  pend_next;
    logic             bad_reg,   bad_next;

    logic [BYTE_W-1:0] b;
    logic              last;
    logic              is_zero;
    logic [POS_W-1:0]  pos_inc;
    logic [1:0]        chk_pend;
    logic              chk_bad;
    logic [POS_W:0]    len_wide;
    logic [POS_W:0]    off_wide;
    logic              used_bad;
    logic [1:0]        used_pend;
    logic [POS_W-1:0]  length;

    assign b       = stage.item.byte_value;
    assign last    = stage.item.last_byte;
    assign is_zero = (b == BYTE_NUL);
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    // Classify the byte against the open string's UTF-8 state
    always_comb
    begin
        chk_pend = pend_reg;
        chk_bad  = bad_reg;
        if (pend_reg != PEND_NONE)
        begin
            if ((b & MASK_2BYTE) != CONT_PATTERN)
            begin
                chk_bad = 1'b1;
            end
            chk_pend = pend_reg - 1'b1;
        end
        else if (b < CONT_PATTERN)
        begin
            if (b < BYTE_SPACE || b == BYTE_DEL)
            begin
                chk_bad = 1'b1;
            end
        end
        else if ((b & MASK_3BYTE) == MASK_2BYTE)
        begin
            chk_pend = PEND_ONE;
        end
        else if ((b & MASK_4BYTE) == MASK_3BYTE)
        begin
            chk_pend = PEND_TWO;
        end
        else if ((b & MASK_LEAD4) == MASK_4BYTE)
        begin
            chk_pend = PEND_THREE;
        end
        else
        begin
            chk_bad = 1'b1;
        end
    end

    // Form length and offset of the closing string, saturated to 24 bits
    always_comb
    begin
        if (is_zero)
        begin
            len_wide  = {1'b0, pos_reg} - {1'b0, begin_reg};
            used_bad  = bad_reg;
            used_pend = pend_reg;
        end
        else
        begin
            len_wide  = {1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1} - {1'b0, begin_reg};
            used_bad  = chk_bad;
            used_pend = chk_pend;
        end
        off_wide = {1'b0, region_start} + {1'b0, begin_reg};
        length   = len_wide[POS_W] ? POS_MAX : len_wide[POS_W-1:0];
    end

    assign scan.emit = stage.valid && (is_zero || last) && (length != '0)
                       && !used_bad && (used_pend == PEND_NONE);
    assign scan.result.string_length = length;
    assign scan.result.string_offset = off_wide[POS_W] ? POS_MAX : off_wide[POS_W-1:0];

    // Advance the string state for the consumed byte
    always_comb
    begin
        pos_next   = pos_reg;
        begin_next = begin_reg;
        pend_next  = pend_reg;
        bad_next   = bad_reg;
        if (advance)
        begin
            if (last)
            begin
                pos_next   = '0;
                begin_next = '0;
                pend_next  = PEND_NONE;
                bad_next   = 1'b0;
            end
            else if (is_zero)
            begin
                pos_next   = pos_inc;
                begin_next = pos_inc;
                pend_next  = PEND_NONE;
                bad_next   = 1'b0;
            end
            else
            begin
                pos_next  = pos_inc;
                pend_next = chk_pend;
                bad_next  = chk_bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            begin_reg <= '0;
            pend_reg  <= PEND_NONE;
            bad_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            pend_reg  <= pend_next;
            bad_reg   <= bad_next;
        end
    end

    // The open string never starts past the current position
    a_begin_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        begin_reg <= pos_reg)
        else $error("string start beyond byte position");

    // A consumed last byte rewinds the region state
    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> pos_reg == '0 && begin_reg == '0 && pend_reg == PEND_NONE)
        else $error("region state not cleared after last byte");

    // Results only come from a terminator or the region end, never empty
    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        scan.emit |-> (is_zero || last) && scan.result.string_length != '0)
        else $error("result emitted without a closing byte");

endmodule

// File: sv/nsu_output_stage.sv
// ============================================================================
// nsu_output_stage - result register of the string scanner
// Holds one finished string result until the sink takes it.
// ============================================================================
module nsu_output_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  nsu_pkg::scan_out_t scan,
    input  logic               advance,
    output logic               free,
    nsu_string_if.source       strings
);
    import nsu_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // The slot is free when empty or drained this cycle
    assign free = !valid_reg || strings.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = scan.emit;
        end
        else if (strings.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the result when a string closes
    always_ff @(posedge clk)
    begin
        if (advance && scan.emit)
        begin
            result_reg <= scan.result;
        end
    end

    assign strings.valid         = valid_reg;
    assign strings.string_offset = result_reg.string_offset;
    assign strings.string_length = result_reg.string_length;

endmodule

// File: sv/null_split_utf8_string_scanner.sv
// ============================================================================
// null_split_utf8_string_scanner - null-split UTF-8 string scanner
// Scans a byte region, splits it at zero bytes and the region end, and
// reports offset and length of each non-empty, well-formed, control-free
// UTF-8 string.
//
//   channel   direction  item                          handshake
//   bytes     sink       byte_value[7:0], last_byte    valid/ready
//   strings   source     string_offset, string_length  valid/ready
//   cfg       write      cfg_wr_data[23:0] region_start cfg_wr_en
//
// One byte item per cycle sustained while strings.ready holds high; a result
// passes from the input register through the scan logic into the result
// register once the edge has accepted its closing byte.
// The scan state update is a single add and compare per byte.
// Reset (rst_n low, asynchronous) empties both registers and clears the
// position state and region_start.
// A stalled result holds the scan stage; bytes.ready follows strings.ready
// combinationally while both the input and the result register are full.
// ============================================================================
module null_split_utf8_string_scanner (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [nsu_pkg::POS_W-1:0] cfg_wr_data,
    nsu_byte_if.sink                  bytes,
    nsu_string_if.source              strings
);
    import nsu_pkg::*;

    logic [POS_W-1:0] region_start_reg;
    stage_t           stage;
    scan_out_t        scan;
    logic             free;
    logic             advance;

    // Write the region start register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            region_start_reg <= cfg_wr_data;
        end
    end

    // Move a byte through the scan logic when the result slot can take it
    assign advance = stage.valid && free;

    nsu_input_stage u_input (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .advance (advance),
        .stage   (stage)
    );

    nsu_scan_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .region_start (region_start_reg),
        .stage        (stage),
        .advance      (advance),
        .scan         (scan)
    );

    nsu_output_stage u_output (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan    (scan),
        .advance (advance),
        .free    (free),
        .strings (strings)
    );

endmodule
